FILE: rtl/lpd_pkg.sv
package lpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int HDR_BYTES = 2;

    // Work handed from the front to the back: one error result, or one
    // buffered packet in the given bank.
    typedef struct packed {
        logic             err;
        logic             bank;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // Back tells the front that a bank has been fully drained.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

FILE: rtl/lpd_if.sv
interface lpd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lpd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [lpd_pkg::BYTE_W-1:0] packet_byte;
    logic                       packet_last;
    logic [lpd_pkg::LEN_W-1:0]  packet_length;
    logic                       status;

    modport source (output valid, output packet_byte, output packet_last,
                    output packet_length, output status, input ready);
    modport sink   (input valid, input packet_byte, input packet_last,
                    input packet_length, input status, output ready);
endinterface

FILE: rtl/lpd_cmd_fifo.sv
module lpd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lpd_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import lpd_pkg::*;

    localparam int DEPTH = 2;

    t_cmd                         r_q [DEPTH];
    logic                         r_wp;
    logic                         r_rp;
    logic [$clog2(DEPTH+1)-1:0]   r_cnt;

    assign o_full  = (r_cnt == ($clog2(DEPTH+1))'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("command queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

FILE: rtl/lpd_front.sv
module lpd_front #(
    parameter  int STORE_BYTES = 64,
    localparam int AW          = $clog2(STORE_BYTES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    lpd_in_if.sink                     i_in,
    output logic                       o_push,
    output lpd_pkg::t_cmd              o_cmd,
    input  logic                       i_full,
    input  lpd_pkg::t_release          i_rel,
    output logic                       o_wr_en,
    output logic [AW:0]                o_wr_addr,
    output logic [lpd_pkg::BYTE_W-1:0] o_wr_data
);
    import lpd_pkg::*;

    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BYTE_W-1:0] r_hi;
    logic              r_err, n_err;
    logic              r_wbank, n_wbank;
    logic [1:0]        r_busy, n_busy;

    logic              accept;
    logic [2*BYTE_W-1:0] hdr_len;
    logic              len_bad;
    logic [LEN_W-1:0]  fill_nx;

    assign i_in.ready = !i_full && !r_busy[r_wbank];
    assign accept     = i_in.valid && i_in.ready;
    assign hdr_len    = {r_hi, i_in.rx_byte};
    assign len_bad    = (hdr_len > (2*BYTE_W)'(STORE_BYTES))
                     || (hdr_len < (2*BYTE_W)'(HDR_BYTES));
    assign fill_nx    = r_fill + 1'b1;

    assign o_wr_en   = accept && !r_err;
    assign o_wr_addr = {r_wbank, r_fill[AW-1:0]};
    assign o_wr_data = i_in.rx_byte;

    always_comb begin
        n_fill     = r_fill;
        n_len      = r_len;
        n_err      = r_err;
        n_wbank    = r_wbank;
        o_push     = 1'b0;
        o_cmd.err  = 1'b0;
        o_cmd.bank = r_wbank;
        o_cmd.len  = r_len;
        if (accept) begin
            if (r_err) begin
                o_push    = 1'b1;
                o_cmd.err = 1'b1;
            end else if (r_fill == '0) begin
                n_fill = fill_nx;
            end else if (r_fill == LEN_W'(1)) begin
                if (len_bad) begin
                    // Bad header: go sticky and report once for this byte
                    n_err     = 1'b1;
                    o_push    = 1'b1;
                    o_cmd.err = 1'b1;
                end else if (hdr_len == (2*BYTE_W)'(HDR_BYTES)) begin
                    // Header-only packet completes right here
                    o_push    = 1'b1;
                    o_cmd.len = LEN_W'(HDR_BYTES);
                    n_fill    = '0;
                    n_wbank   = ~r_wbank;
                end else begin
                    n_len  = hdr_len[LEN_W-1:0];
                    n_fill = fill_nx;
                end
            end else if (fill_nx == r_len) begin
                o_push  = 1'b1;
                n_fill  = '0;
                n_wbank = ~r_wbank;
            end else begin
                n_fill = fill_nx;
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (o_push && !o_cmd.err) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_err && r_fill == '0) begin
            r_hi <= i_in.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_len   <= '0;
            r_err   <= 1'b0;
            r_wbank <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_err   <= n_err;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

`ifndef ASSERT_OFF
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("framing error cleared without reset");
    a_push_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> accept)
        else $error("command pushed without an input transfer");
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel.valid |-> r_busy[i_rel.bank])
        else $error("release of a bank that is not in use");
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_err && r_fill >= LEN_W'(HDR_BYTES)) |-> (r_fill < r_len))
        else $error("fill count passed the frame length");
`endif

endmodule

FILE: rtl/lpd_back.sv
module lpd_back #(
    parameter  int STORE_BYTES = 64,
    localparam int AW          = $clog2(STORE_BYTES)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [AW:0]                i_wr_addr,
    input  logic [lpd_pkg::BYTE_W-1:0] i_wr_data,
    input  lpd_pkg::t_cmd              i_cmd,
    input  logic                       i_empty,
    output logic                       o_pop,
    output lpd_pkg::t_release          o_rel,
    lpd_out_if.source                  o_out
);
    import lpd_pkg::*;

    localparam int MEM_DEPTH = 2 * (1 << AW);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SEND} t_state;

    logic [BYTE_W-1:0] r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    t_state            r_state;
    logic              r_bank;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_idx;
    logic              r_is_err;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic [LEN_W-1:0]  r_plen;
    logic              r_status;

    logic              rd_en;
    logic [AW:0]       rd_addr;
    logic              sent;
    logic [LEN_W-1:0]  idx_nx;

    assign sent   = (r_state == S_SEND) && o_out.ready;
    assign idx_nx = r_idx + 1'b1;
    assign o_pop  = (r_state == S_IDLE) && !i_empty;

    assign o_rel.valid = sent && !r_is_err && r_last;
    assign o_rel.bank  = r_bank;

    assign o_out.valid         = r_valid;
    assign o_out.packet_byte   = r_byte;
    assign o_out.packet_last   = r_last;
    assign o_out.packet_length = r_plen;
    assign o_out.status        = r_status;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = {r_bank, idx_nx[AW-1:0]};
        if (o_pop && !i_cmd.err) begin
            rd_en   = 1'b1;
            rd_addr = {i_cmd.bank, {AW{1'b0}}};
        end else if (sent && !r_is_err && !r_last) begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_is_err <= 1'b0;
            r_bank   <= 1'b0;
            r_len    <= '0;
            r_idx    <= '0;
            r_last   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_is_err <= i_cmd.err;
                        if (i_cmd.err) begin
                            r_valid  <= 1'b1;
                            r_byte   <= '0;
                            r_last   <= 1'b1;
                            r_plen   <= '0;
                            r_status <= 1'b1;
                            r_state  <= S_SEND;
                        end else begin
                            r_bank  <= i_cmd.bank;
                            r_len   <= i_cmd.len;
                            r_idx   <= '0;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_valid  <= 1'b1;
                    r_byte   <= r_rdata;
                    r_last   <= (idx_nx == r_len);
                    r_plen   <= r_len;
                    r_status <= 1'b0;
                    r_state  <= S_SEND;
                end
                S_SEND: begin
                    if (o_out.ready) begin
                        r_valid <= 1'b0;
                        if (r_is_err || r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= idx_nx;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_valid_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid == (r_state == S_SEND))
        else $error("output valid out of step with the sequencer");
    a_err_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> (r_last && r_plen == '0 && r_byte == '0))
        else $error("malformed error result");
    a_idx_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && !r_is_err) |-> (r_idx < r_len))
        else $error("read index beyond packet length");
`endif

endmodule

FILE: rtl/length_prefix_packet_deframer_core.sv
// Length-prefixed packet deframer. Each packet on i_in opens with a 16-bit
// big-endian total length that counts its own two bytes; once the last byte
// of a packet is in, the whole packet (header included) leaves on o_out, one
// byte per transfer, with packet_last on the final byte and packet_length on
// every byte. A header length above STORE_BYTES or below 2 sets a sticky
// framing error: from then on each input byte yields one result with status
// 1, packet_last 1 and the other fields 0, until reset. The front takes one
// byte per cycle into one of two packet banks; it stalls only while the bank
// it would fill is still draining or the two-entry command queue is full.
// The back sends the stored bytes one at a time, each through a registered
// memory read and then the output register, and reads no new byte until
// the last one is accepted; the drain rate bounds sustained throughput.
// No clearing pass follows reset.
module length_prefix_packet_deframer_core #(
    parameter int STORE_BYTES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpd_in_if.sink    i_in,
    lpd_out_if.source o_out
);
    import lpd_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    t_cmd              push_cmd;
    t_cmd              head_cmd;
    t_release          rel;
    logic              wr_en;
    logic [AW:0]       wr_addr;
    logic [BYTE_W-1:0] wr_data;

    lpd_front #(.STORE_BYTES(STORE_BYTES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .i_full    (full),
        .i_rel     (rel),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    lpd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    lpd_back #(.STORE_BYTES(STORE_BYTES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_cmd     (head_cmd),
        .i_empty   (empty),
        .o_pop     (pop),
        .o_rel     (rel),
        .o_out     (o_out)
    );

endmodule

FILE: bench/length_prefix_packet_deframer_core_tb.sv
module length_prefix_packet_deframer_core_tb;

    import lpd_pkg::*;

    localparam int STORE_BYTES = 64;
    localparam int HALF_PERIOD = 5;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_TAIL  = 2 * STORE_BYTES + 8;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic              packet_last;
        logic [LEN_W-1:0]  packet_length;
        logic              status;
    } t_packet_result;

    logic i_clk;
    logic i_rst_n;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();

    length_prefix_packet_deframer_core #(
        .STORE_BYTES(STORE_BYTES)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Deframer state as the testbench tracks it
    logic [BYTE_W-1:0] frame_store [STORE_BYTES];
    int unsigned       frame_fill;
    logic [15:0]       frame_len;
    bit                framing_error;

    t_packet_result pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int bytes_sent;
    int packets_seen;
    int error_results_seen;
    int idle_cycles;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Work out the results that one accepted byte causes
    task automatic deframe_predict(input logic [BYTE_W-1:0] rx);
        t_packet_result res;
        if (framing_error) begin
            res = '{packet_byte: '0, packet_last: 1'b1, packet_length: '0, status: 1'b1};
            pending_results.push_back(res);
            return;
        end
        if (frame_fill < STORE_BYTES) begin
            frame_store[frame_fill] = rx;
            frame_fill++;
        end
        if (frame_fill < HDR_BYTES)
            return;
        if (frame_fill == HDR_BYTES) begin
            frame_len = {frame_store[0], frame_store[1]};
            if (frame_len > STORE_BYTES || frame_len < HDR_BYTES) begin
                framing_error = 1'b1;
                res = '{packet_byte: '0, packet_last: 1'b1, packet_length: '0,
                        status: 1'b1};
                pending_results.push_back(res);
                return;
            end
        end
        if (frame_fill < frame_len)
            return;
        for (int i = 0; i < frame_fill; i++) begin
            res.packet_byte   = frame_store[i];
            res.packet_last   = (i + 1 == frame_fill);
            res.packet_length = LEN_W'(frame_fill);
            res.status        = 1'b0;
            pending_results.push_back(res);
        end
        frame_fill = 0;
        frame_len  = '0;
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid   <= 1'b0;
            in_ch.rx_byte <= BYTE_W'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx;
        do @(posedge i_clk); while (!in_ch.ready);
        deframe_predict(rx);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input int unsigned len);
        send_byte(BYTE_W'(len >> 8));
        send_byte(BYTE_W'(len));
        for (int i = 2; i < len; i++)
            send_byte(BYTE_W'($urandom));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    task automatic test_directed_packets();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // header-only packet, emitted on its second byte
        send_packet(HDR_BYTES);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h05);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'h04);
        send_byte(8'hFF);
        send_byte(8'hFF);
        wait_drained();
    endtask

    task automatic test_random_packets(input int idle_pct, input int stall_pct,
                                       input bit with_full_packet);
        int start;
        int unsigned len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        if (with_full_packet)
            send_packet(STORE_BYTES);
        while (bytes_sent - start < 20) begin
            // mostly short packets, now and then a long one
            if ($urandom_range(7) == 0)
                len = $urandom_range(STORE_BYTES, 13);
            else
                len = $urandom_range(12, HDR_BYTES);
            send_packet(len);
        end
        wait_drained();
    endtask

    // Sticky: only one bad header per run, chosen at random
    task automatic test_framing_error();
        logic [15:0] bad_len;
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        case ($urandom_range(3))
            0:       bad_len = 16'h0000;
            1:       bad_len = 16'h0001;
            2:       bad_len = 16'(STORE_BYTES + 1);
            default: bad_len = 16'($urandom_range(16'hFFFF, STORE_BYTES + 1));
        endcase
        send_packet(3);
        send_byte(bad_len[15:8]);
        send_byte(bad_len[7:0]);
        repeat (6) send_byte(BYTE_W'($urandom));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'h02);
        repeat (4) send_byte(BYTE_W'($urandom));
        wait_drained();
    endtask

    // Receiver back-pressure
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_packet_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: byte %0h last %0b length %0d status %0b",
                       out_ch.packet_byte, out_ch.packet_last, out_ch.packet_length,
                       out_ch.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.packet_byte !== want.packet_byte) begin
                    $error("packet_byte: expected %0h, actual %0h",
                           want.packet_byte, out_ch.packet_byte);
                    fail_count++;
                end
                if (out_ch.packet_last !== want.packet_last) begin
                    $error("packet_last: expected %0b, actual %0b",
                           want.packet_last, out_ch.packet_last);
                    fail_count++;
                end
                if (out_ch.packet_length !== want.packet_length) begin
                    $error("packet_length: expected %0d, actual %0d",
                           want.packet_length, out_ch.packet_length);
                    fail_count++;
                end
                if (out_ch.status !== want.status) begin
                    $error("status: expected %0b, actual %0b", want.status, out_ch.status);
                    fail_count++;
                end
                if (want.status)
                    error_results_seen++;
                else if (want.packet_last)
                    packets_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer in %0d cycles", STALL_LIMIT);
            $display("FAIL length_prefix_packet_deframer_core");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.rx_byte      = '0;
        out_ch.ready       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        fail_count         = 0;
        bytes_sent         = 0;
        packets_seen       = 0;
        error_results_seen = 0;
        idle_cycles        = 0;
        frame_fill         = 0;
        frame_len          = '0;
        framing_error      = 1'b0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_packets();
        test_random_packets(0, 0, 1'b1);
        test_random_packets(63, 0, 1'b0);
        test_random_packets(0, 63, 1'b1);
        test_random_packets(35, 35, 1'b0);
        test_framing_error();

        $display("sent %0d bytes under four idle/stall mixes", bytes_sent);
        $display("checked %0d packets and %0d framing error results",
                 packets_seen, error_results_seen);
        if (fail_count == 0)
            $display("PASS length_prefix_packet_deframer_core");
        else
            $display("FAIL length_prefix_packet_deframer_core");
        $finish;
    end

endmodule

FILE: files.f
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/lpd_cmd_fifo.sv
rtl/lpd_front.sv
rtl/lpd_back.sv
rtl/length_prefix_packet_deframer_core.sv
bench/length_prefix_packet_deframer_core_tb.sv
